// ===== rtl/core/mmh_pkg.sv =====
// Package for the min-max heap: widths, command and status codes, memory request type.
// No dependencies.
package mmh_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = $clog2(Capacity);
  localparam int unsigned CountWidth = $clog2(Capacity + 1);

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [CountWidth-1:0] count_t;

  localparam logic [1:0] CmdPush = 2'd0;
  localparam logic [1:0] CmdPopMin = 2'd1;
  localparam logic [1:0] CmdPopMax = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatFull = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // depth parity of a node index: level = floor(log2(i+1))
  function automatic logic is_min_level(input addr_t i);
    logic [AddrWidth:0] v;
    logic par;
    v = {1'b0, i} + 1'b1;
    par = 1'b0;
    for (int b = 0; b <= AddrWidth; b++) begin
      if (v[b]) begin
        par = b[0];
      end
    end
    return !par;
  endfunction
endpackage

// ===== rtl/core/mmh_ram.sv =====
// Heap store: synchronous RAM with one write port and one registered read port.
// Depends on mmh_pkg.
module mmh_ram (
  input  logic              clk_i,
  input  mmh_pkg::mem_req_t req_i,
  output mmh_pkg::data_t    rdata_o
);
  import mmh_pkg::*;

  data_t mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end
endmodule

// ===== rtl/core/double_ended_priority_heap.sv =====
// Min-max heap top level: command sequencer around one heap RAM.
// Depends on mmh_pkg and mmh_ram.
// Commands are handled one at a time: a push bubbles up by grandparent steps, a pop
// trickles down two levels per step; refused and unused commands only report the summary.
// One beat in flight; the next input beat is taken no earlier than the cycle after the result beat.
// Reset clears the count and control; the RAM content stays undefined.
module double_ended_priority_heap (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // cmd[1:0], value[33:2], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata   // status, removed, min, max, count, pad
);
  import mmh_pkg::*;

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StPopRd  = 5'd1;
  localparam logic [4:0] StPopRw  = 5'd2;
  localparam logic [4:0] StLastRd = 5'd3;
  localparam logic [4:0] StTdCur  = 5'd5;
  localparam logic [4:0] StTdKid  = 5'd6;
  localparam logic [4:0] StTdKw   = 5'd7;
  localparam logic [4:0] StTdSw   = 5'd8;
  localparam logic [4:0] StTdPRd  = 5'd9;
  localparam logic [4:0] StTdPW   = 5'd10;
  localparam logic [4:0] StTdPW2  = 5'd11;
  localparam logic [4:0] StPuPRd  = 5'd12;
  localparam logic [4:0] StPuPW   = 5'd13;
  localparam logic [4:0] StBuRd   = 5'd14;
  localparam logic [4:0] StBuW    = 5'd15;
  localparam logic [4:0] StSum0   = 5'd16;
  localparam logic [4:0] StSum1   = 5'd17;
  localparam logic [4:0] StSum2   = 5'd18;
  localparam logic [4:0] StSumW   = 5'd19;
  localparam logic [4:0] StOut    = 5'd20;
  localparam logic [4:0] StPopMx  = 5'd21;
  localparam logic [4:0] StPopMx2 = 5'd22;

  logic [4:0] st_q, st_d;
  count_t cnt_q, cnt_d;
  addr_t i_q, i_d;       // current node
  addr_t m_q, m_d;       // best descendant
  addr_t rd_q, rd_d;     // address under read
  logic [2:0] k_q, k_d;
  logic found_q, found_d, onmin_q, onmin_d;
  data_t x_q, x_d;       // value being moved
  data_t mv_q, mv_d;     // best descendant value
  data_t rem_q, rem_d, mn_q, mn_d, mx_q, mx_d, t_q, t_d;
  logic [1:0] cmd_q, cmd_d, stat_q, stat_d;
  mem_req_t req;
  data_t rdata;

  mmh_ram u_ram (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  function automatic logic better(input logic on_min, input data_t a, input data_t b);
    return on_min ? (a < b) : (b < a);
  endfunction

  logic [AddrWidth+2:0] cidx;
  always_comb begin
    if (k_q <= 3'd2) begin
      cidx = {2'b0, i_q, 1'b0} + (AddrWidth+3)'(k_q);
    end else begin
      cidx = {1'b0, i_q, 2'b0} + (AddrWidth+3)'(k_q);
    end
  end
  logic cvalid;
  assign cvalid = cidx < (AddrWidth+3)'(cnt_q);

  assign s_axis_tready = (st_q == StIdle) && !m_axis_tvalid;

  logic out_v_q, out_v_d;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {3'd0, cnt_q, mx_q, mn_q, rem_q, stat_q};

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; m_d = m_q; rd_d = rd_q; k_d = k_q;
    found_d = found_q; onmin_d = onmin_q; x_d = x_q; mv_d = mv_q; rem_d = rem_q;
    mn_d = mn_q; mx_d = mx_q; t_d = t_q; cmd_d = cmd_q; stat_d = stat_q;
    out_v_d = out_v_q;
    req = '0;
    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
    end
    unique case (st_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d = s_axis_tdata[1:0];
          x_d = s_axis_tdata[33:2];
          rem_d = '0;
          stat_d = StatOk;
          if (s_axis_tdata[1:0] == CmdPush) begin
            if (cnt_q >= count_t'(Capacity)) begin
              stat_d = StatFull;
              st_d = StSum0;
            end else begin
              req.we = 1'b1; req.waddr = addr_t'(cnt_q); req.wdata = s_axis_tdata[33:2];
              i_d = addr_t'(cnt_q);
              cnt_d = cnt_q + 1'b1;
              if (cnt_q == '0) begin
                st_d = StSum0;
              end else begin
                req.re = 1'b1; req.raddr = addr_t'((cnt_q - 1'b1) >> 1);
                rd_d = addr_t'((cnt_q - 1'b1) >> 1);
                st_d = StPuPRd;
              end
            end
          end else if (s_axis_tdata[1:0] == CmdPopMin || s_axis_tdata[1:0] == CmdPopMax) begin
            if (cnt_q == '0) begin
              stat_d = StatEmpty;
              st_d = StSum0;
            end else if (s_axis_tdata[1:0] == CmdPopMax && cnt_q >= count_t'(3)) begin
              req.re = 1'b1; req.raddr = addr_t'(1);
              st_d = StPopMx;
            end else begin
              i_d = (s_axis_tdata[1:0] == CmdPopMax && cnt_q == count_t'(2))
                  ? addr_t'(1) : addr_t'(0);
              req.re = 1'b1; req.raddr = i_d;
              st_d = StPopRd;
            end
          end else begin
            st_d = StSum0;
          end
        end
      end
      StPopMx: begin
        t_d = rdata;
        req.re = 1'b1; req.raddr = addr_t'(2);
        st_d = StPopMx2;
      end
      StPopMx2: begin
        i_d = (rdata < t_q) ? addr_t'(1) : addr_t'(2);
        rem_d = (rdata < t_q) ? t_q : rdata;
        cnt_d = cnt_q - 1'b1;
        st_d = StPopRw;
      end
      StPopRd: begin
        rem_d = rdata;
        cnt_d = cnt_q - 1'b1;
        st_d = StPopRw;
      end
      StPopRw: begin
        if ({1'b0, i_q} < {1'b0, cnt_q}) begin
          req.re = 1'b1; req.raddr = addr_t'(cnt_q);
          st_d = StLastRd;
        end else begin
          st_d = StSum0;
        end
      end
      StLastRd: begin
        x_d = rdata;
        req.we = 1'b1; req.waddr = i_q; req.wdata = rdata;
        onmin_d = is_min_level(i_q);
        k_d = 3'd1; found_d = 1'b0;
        st_d = StTdKid;
      end
      StTdKid: begin
        // scan children and grandchildren, one read per step
        if (k_q == 3'd7) begin
          st_d = found_q ? StTdKw : StSum0;
        end else if (cvalid) begin
          req.re = 1'b1; req.raddr = addr_t'(cidx); rd_d = addr_t'(cidx);
          st_d = StTdCur;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StTdCur: begin
        if (!found_q || better(onmin_q, rdata, mv_q)) begin
          mv_d = rdata; m_d = rd_q; found_d = 1'b1;
        end
        k_d = k_q + 1'b1;
        st_d = StTdKid;
      end
      StTdKw: begin
        if (!better(onmin_q, mv_q, x_q)) begin
          st_d = StSum0;
        end else begin
          req.we = 1'b1; req.waddr = i_q; req.wdata = mv_q;
          if ({2'b0, m_q} >= {i_q, 2'b0} + 12'd3) begin
            req.re = 1'b1; req.raddr = addr_t'((m_q - 1'b1) >> 1);
            st_d = StTdPRd;
          end else begin
            st_d = StTdSw;
          end
        end
      end
      StTdSw: begin
        req.we = 1'b1; req.waddr = m_q; req.wdata = x_q;
        st_d = StSum0;
      end
      StTdPRd: begin
        t_d = rdata;
        if (better(onmin_q, rdata, x_q)) begin
          req.we = 1'b1; req.waddr = addr_t'((m_q - 1'b1) >> 1); req.wdata = x_q;
          st_d = StTdPW2;
        end else begin
          st_d = StTdPW;
        end
      end
      StTdPW2: begin
        req.we = 1'b1; req.waddr = m_q; req.wdata = t_q;
        x_d = t_q;
        i_d = m_q; k_d = 3'd1; found_d = 1'b0;
        st_d = StTdKid;
      end
      StTdPW: begin
        req.we = 1'b1; req.waddr = m_q; req.wdata = x_q;
        i_d = m_q; k_d = 3'd1; found_d = 1'b0;
        st_d = StTdKid;
      end
      StPuPRd: begin
        onmin_d = is_min_level(i_q);
        if (better(!is_min_level(i_q), x_q, rdata)) begin
          req.we = 1'b1; req.waddr = i_q; req.wdata = rdata;
          onmin_d = !is_min_level(i_q);
          i_d = rd_q;
        end
        st_d = StPuPW;
      end
      StPuPW: begin
        // x_q is virtually at i_q; write it when bubbling ends
        if (i_q >= addr_t'(3)) begin
          rd_d = addr_t'((((i_q - 1'b1) >> 1) - 1'b1) >> 1);
          req.re = 1'b1; req.raddr = addr_t'((((i_q - 1'b1) >> 1) - 1'b1) >> 1);
          st_d = StBuRd;
        end else begin
          req.we = 1'b1; req.waddr = i_q; req.wdata = x_q;
          st_d = StSum0;
        end
      end
      StBuRd: begin
        if (better(onmin_q, x_q, rdata)) begin
          req.we = 1'b1; req.waddr = i_q; req.wdata = rdata;
          i_d = rd_q;
          st_d = StPuPW;
        end else begin
          st_d = StBuW;
        end
      end
      StBuW: begin
        req.we = 1'b1; req.waddr = i_q; req.wdata = x_q;
        st_d = StSum0;
      end
      StSum0: begin
        req.re = 1'b1; req.raddr = addr_t'(0);
        st_d = StSum1;
      end
      StSum1: begin
        mn_d = (cnt_q == '0) ? '0 : rdata;
        mx_d = (cnt_q == '0) ? '0 : rdata;
        req.re = 1'b1; req.raddr = addr_t'(1);
        st_d = StSum2;
      end
      StSum2: begin
        if (cnt_q >= count_t'(2)) begin
          mx_d = rdata;
        end
        req.re = 1'b1; req.raddr = addr_t'(2);
        st_d = StSumW;
      end
      StSumW: begin
        if (cnt_q >= count_t'(3) && mx_q < rdata) begin
          mx_d = rdata;
        end
        st_d = StOut;
      end
      StOut: begin
        out_v_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; m_q <= m_d; rd_q <= rd_d; k_q <= k_d; found_q <= found_d;
    onmin_q <= onmin_d; x_q <= x_d; mv_q <= mv_d; rem_q <= rem_d; mn_q <= mn_d;
    mx_q <= mx_d; t_q <= t_d; cmd_q <= cmd_d; stat_q <= stat_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= count_t'(Capacity))
    else $error("count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tready |-> st_q == StIdle)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q != StIdle) |=> !(s_axis_tvalid && s_axis_tready) || $past(st_q) == StOut)
    else $error("beat taken mid operation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cmd_q == CmdPush && stat_q == StatOk && st_q == StOut) |-> rem_q == '0)
    else $error("push reports removed value");
endmodule
